// ===== rtl/core/wbpm_pkg.sv =====
// Package: shared types and constants of the wildcard byte pattern matcher.
`default_nettype none
package wbpm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned PosW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned FillW      = $clog2(MaxPattern + 1);
  localparam int unsigned LenW       = 6;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 32;
  localparam int unsigned EntryW     = ByteW + 1;

  typedef enum logic [CmdW-1:0] {
    CmdLoad = 2'd0,
    CmdScan = 2'd1,
    CmdEnd  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KindAck     = 2'd0,
    KindScan    = 2'd1,
    KindSummary = 2'd2
  } kind_e;

  // per-transaction operation strobes
  typedef struct packed {
    logic load;
    logic scan;
    logic done;
  } op_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [IdxW-1:0]  entry_index;
    logic [ByteW-1:0] byte_value;
    logic             is_wildcard;
  } item_t;

  typedef struct packed {
    kind_e             result_kind;
    logic              matched;
    logic [CountW-1:0] start_offset;
    logic [CountW-1:0] match_total;
    logic              single_match;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/wbpm_if.sv =====
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface wbpm_in_if;
  logic                      valid;
  logic                      ready;
  logic [wbpm_pkg::CmdW-1:0]  command;
  logic [wbpm_pkg::IdxW-1:0]  entry_index;
  logic [wbpm_pkg::ByteW-1:0] byte_value;
  logic                      is_wildcard;

  modport source (output valid, command, entry_index, byte_value, is_wildcard, input ready);
  modport sink   (input valid, command, entry_index, byte_value, is_wildcard, output ready);
endinterface

interface wbpm_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 result_kind;
  logic                       matched;
  logic [wbpm_pkg::CountW-1:0] start_offset;
  logic [wbpm_pkg::CountW-1:0] match_total;
  logic                       single_match;

  modport source (output valid, result_kind, matched, start_offset, match_total,
                  single_match, input ready);
  modport sink   (input valid, result_kind, matched, start_offset, match_total,
                  single_match, output ready);
endinterface

interface wbpm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wbpm_pkg::LenW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wbpm_pat_store.sv =====
// Pattern store: entry registers and alignment of the pattern to the window.
`default_nettype none
module wbpm_pat_store (
  input  wire logic                                  clk_i,
  input  wire logic                                  load_i,
  input  wire logic [wbpm_pkg::IdxW-1:0]             idx_i,
  input  wire logic [wbpm_pkg::ByteW-1:0]            byte_i,
  input  wire logic                                  wild_i,
  input  wire logic [wbpm_pkg::FillW-1:0]            len_i,
  output logic [wbpm_pkg::MaxPattern-1:0][wbpm_pkg::EntryW-1:0] aligned_o
);

  logic [wbpm_pkg::EntryW-1:0]                         entry_q [wbpm_pkg::MaxPattern];
  logic [wbpm_pkg::PosW-1:0]                           wr_addr;
  logic                                                wr_ok;
  logic [wbpm_pkg::MaxPattern*wbpm_pkg::EntryW-1:0]    rev_flat;
  logic [wbpm_pkg::MaxPattern*wbpm_pkg::EntryW-1:0]    aligned_flat;
  logic [wbpm_pkg::FillW-1:0]                          shift;

  assign wr_addr = wbpm_pkg::PosW'(idx_i);
  assign wr_ok   = (32'(idx_i) < wbpm_pkg::MaxPattern);

  // no reset: entries are undefined until loaded
  always_ff @(posedge clk_i) begin
    if (load_i && wr_ok) begin
      entry_q[wr_addr] <= {wild_i, byte_i};
    end
  end

  // reversed order, then shift so window position p meets entry len-1-p
  always_comb begin
    for (int p = 0; p < wbpm_pkg::MaxPattern; p++) begin
      rev_flat[p*wbpm_pkg::EntryW +: wbpm_pkg::EntryW] = entry_q[wbpm_pkg::MaxPattern-1-p];
    end
  end

  assign shift        = wbpm_pkg::FillW'(wbpm_pkg::MaxPattern) - len_i;
  assign aligned_flat = rev_flat >> (shift * wbpm_pkg::EntryW);
  assign aligned_o    = aligned_flat;

endmodule
`default_nettype wire

// ===== rtl/core/wbpm_window.sv =====
// Byte window: shift line, fill count and parallel wildcard compare.
`default_nettype none
module wbpm_window (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire wbpm_pkg::op_t                         op_i,
  input  wire logic [wbpm_pkg::ByteW-1:0]            byte_i,
  input  wire logic [wbpm_pkg::FillW-1:0]            len_i,
  input  wire logic [wbpm_pkg::MaxPattern-1:0][wbpm_pkg::EntryW-1:0] pattern_i,
  output logic                                       hit_o
);

  logic [wbpm_pkg::ByteW-1:0]  win_q [wbpm_pkg::MaxPattern];
  logic [wbpm_pkg::ByteW-1:0]  win_d [wbpm_pkg::MaxPattern];
  logic [wbpm_pkg::FillW-1:0]  fill_q, fill_d;
  logic [wbpm_pkg::MaxPattern-1:0] pos_ok;

  always_comb begin
    win_d[0] = byte_i;
    for (int p = 1; p < wbpm_pkg::MaxPattern; p++) begin
      win_d[p] = win_q[p-1];
    end
  end

  assign fill_d = (fill_q == wbpm_pkg::FillW'(wbpm_pkg::MaxPattern)) ? fill_q
                                                                      : fill_q + 1'b1;

  // window contents need no reset, the fill count guards them
  always_ff @(posedge clk_i) begin
    if (op_i.scan) begin
      for (int p = 0; p < wbpm_pkg::MaxPattern; p++) begin
        win_q[p] <= win_d[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (op_i.done) begin
      fill_q <= '0;
    end else if (op_i.scan) begin
      fill_q <= fill_d;
    end
  end

  always_comb begin
    for (int p = 0; p < wbpm_pkg::MaxPattern; p++) begin
      pos_ok[p] = (wbpm_pkg::FillW'(p) >= len_i)
               || pattern_i[p][wbpm_pkg::ByteW]
               || (win_d[p] == pattern_i[p][wbpm_pkg::ByteW-1:0]);
    end
  end

  assign hit_o = (fill_d >= len_i) && (&pos_ok);

endmodule
`default_nettype wire

// ===== rtl/core/wbpm_stream.sv =====
// Stream bookkeeping: byte offset, match count, first offset, result build.
`default_nettype none
module wbpm_stream (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wbpm_pkg::op_t               op_i,
  input  wire logic [wbpm_pkg::FillW-1:0]  len_i,
  input  wire logic                        hit_i,
  output wbpm_pkg::res_t                   res_o
);

  logic [wbpm_pkg::CountW-1:0] seen_q, seen_d;
  logic [wbpm_pkg::CountW-1:0] count_q, count_d;
  logic [wbpm_pkg::CountW-1:0] first_q, first_d;
  logic [wbpm_pkg::CountW-1:0] start;
  logic                        hit;

  assign hit   = op_i.scan && hit_i;
  assign start = seen_q - (wbpm_pkg::CountW'(len_i) - 1'b1);

  always_comb begin
    seen_d  = seen_q;
    count_d = count_q;
    first_d = first_q;
    res_o   = '0;
    if (op_i.scan) begin
      seen_d = seen_q + 1'b1;
      if (hit) begin
        if (count_q == '0) begin
          first_d = start;
        end
        if (count_q != '1) begin
          count_d = count_q + 1'b1;
        end
      end
      res_o.result_kind  = wbpm_pkg::KindScan;
      res_o.matched      = hit;
      res_o.start_offset = hit ? start : '0;
      res_o.match_total  = count_d;
    end else if (op_i.done) begin
      seen_d  = '0;
      count_d = '0;
      first_d = '0;
      res_o.result_kind  = wbpm_pkg::KindSummary;
      res_o.start_offset = (count_q != '0) ? first_q : '0;
      res_o.match_total  = count_q;
      res_o.single_match = (count_q == wbpm_pkg::CountW'(1));
    end else begin
      res_o.result_kind = wbpm_pkg::KindAck;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      count_q <= '0;
      first_q <= '0;
    end else begin
      seen_q  <= seen_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wildcard_byte_pattern_matcher.sv =====
// Top level: wildcard byte pattern matcher with input and result registers.
//
//   channel   | dir | carries
//   ----------+-----+----------------------------------------------------
//   item_i    | in  | command, entry_index, byte_value, is_wildcard
//   result_o  | out | result_kind, matched, start_offset, match_total,
//             |     | single_match
//   cfg_i     | in  | data = pattern_length (always ready)
//
// One transaction per cycle sustained while results are taken. A result
// passes the input register, then the result register, after its item is
// taken; the compare of all window positions at once is combinational
// between the two.
// Reset is asynchronous, active low; it clears control and the stream
// counters but not the pattern or window contents.
// A stalled result holds the result register; the input register still
// drains an unknown command (which gives no result) and otherwise waits,
// so item_i.ready falls only when both registers are full and stalled.
`default_nettype none
module wildcard_byte_pattern_matcher (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  wbpm_in_if.sink        item_i,
  wbpm_out_if.source     result_o,
  wbpm_cfg_if.sink       cfg_i
);

  // active pattern length, clamped to 1..MaxPattern on write
  logic [wbpm_pkg::FillW-1:0] len_q, len_d;

  // input register
  logic            in_vld_q, in_vld_d;
  wbpm_pkg::item_t item_q;
  logic            in_take;

  // result register
  logic            out_vld_q, out_vld_d;
  wbpm_pkg::res_t  res_q;
  wbpm_pkg::res_t  res;
  logic            out_free;

  // decode and advance
  wbpm_pkg::op_t   op_dec, op;
  logic            has_result;
  logic            advance;

  logic [wbpm_pkg::MaxPattern-1:0][wbpm_pkg::EntryW-1:0] aligned;
  logic            hit;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_comb begin
    len_d = len_q;
    if (cfg_i.valid) begin
      if (cfg_i.data == '0) begin
        len_d = wbpm_pkg::FillW'(1);
      end else if (32'(cfg_i.data) > wbpm_pkg::MaxPattern) begin
        len_d = wbpm_pkg::FillW'(wbpm_pkg::MaxPattern);
      end else begin
        len_d = wbpm_pkg::FillW'(cfg_i.data);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= wbpm_pkg::FillW'(1);
    end else begin
      len_q <= len_d;
    end
  end

  // ---------------------------------------------------------------------
  // Command decode of the registered item
  // ---------------------------------------------------------------------
  always_comb begin
    op_dec = '0;
    unique case (wbpm_pkg::cmd_e'(item_q.command))
      wbpm_pkg::CmdLoad: op_dec.load = 1'b1;
      wbpm_pkg::CmdScan: op_dec.scan = 1'b1;
      wbpm_pkg::CmdEnd:  op_dec.done = 1'b1;
      default:           op_dec      = '0;   // unknown command: dropped
    endcase
  end

  assign has_result = op_dec.load || op_dec.scan || op_dec.done;
  assign out_free   = !out_vld_q || result_o.ready;
  assign advance    = in_vld_q && (!has_result || out_free);
  assign op         = advance ? op_dec : '0;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  assign item_i.ready = !in_vld_q || advance;
  assign in_take      = item_i.valid && item_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{command:     item_i.command,
                  entry_index: item_i.entry_index,
                  byte_value:  item_i.byte_value,
                  is_wildcard: item_i.is_wildcard};
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  wbpm_pat_store u_pat_store (
    .clk_i     (clk_i),
    .load_i    (op.load),
    .idx_i     (item_q.entry_index),
    .byte_i    (item_q.byte_value),
    .wild_i    (item_q.is_wildcard),
    .len_i     (len_q),
    .aligned_o (aligned)
  );

  wbpm_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .byte_i    (item_q.byte_value),
    .len_i     (len_q),
    .pattern_i (aligned),
    .hit_o     (hit)
  );

  wbpm_stream u_stream (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .len_i  (len_q),
    .hit_i  (hit),
    .res_o  (res)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && has_result) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      res_q <= res;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.result_kind  = res_q.result_kind;
  assign result_o.matched      = res_q.matched;
  assign result_o.start_offset = res_q.start_offset;
  assign result_o.match_total  = res_q.match_total;
  assign result_o.single_match = res_q.single_match;

endmodule
`default_nettype wire

// ===== rtl/core/wbpm_checker.sv =====
// Checker: port-level assertions on the matcher, bound to the top level.
`default_nettype none
module wbpm_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [1:0]                   result_kind_i,
  input wire logic                         matched_i,
  input wire logic [wbpm_pkg::CountW-1:0]  start_offset_i,
  input wire logic [wbpm_pkg::CountW-1:0]  match_total_i,
  input wire logic                         single_match_i
);

  // stalled result stays valid and keeps its payload, single_match apart
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i)
      && $stable(start_offset_i) && $stable(match_total_i) && $stable(matched_i))
    else $error("result changed while stalled");

  // load acknowledge carries nothing else
  a_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == wbpm_pkg::KindAck) |->
      !matched_i && (start_offset_i == '0) && (match_total_i == '0) && !single_match_i)
    else $error("load acknowledge with non-zero fields");

  // scan without a match has no offset; a hit always counts
  a_scan_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == wbpm_pkg::KindScan) |->
      !single_match_i && (matched_i || (start_offset_i == '0))
      && (!matched_i || (match_total_i != '0)))
    else $error("scan result fields inconsistent");

  // summary: no matched flag, single match means a count of one
  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == wbpm_pkg::KindSummary) |->
      !matched_i && (single_match_i == (match_total_i == wbpm_pkg::CountW'(1)))
      && ((match_total_i != '0) || (start_offset_i == '0)))
    else $error("summary fields inconsistent");

endmodule

bind wildcard_byte_pattern_matcher wbpm_checker u_wbpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .result_kind_i  (result_o.result_kind),
  .matched_i      (result_o.matched),
  .start_offset_i (result_o.start_offset),
  .match_total_i  (result_o.match_total),
  .single_match_i (result_o.single_match)
);
`default_nettype wire
